// ===== hdl/wps_pkg.sv =====
// shared types and constants for the led data line serializer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

    localparam int COLOR_W  = 8;
    localparam int PIXEL_W  = 3 * COLOR_W;
    localparam int TICK_W   = 10;
    localparam int PERIOD_W = 8;
    localparam int BIT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_PERIODS = 2'd3;

    localparam logic [TICK_W-1:0]   PERIOD_LAST_RST   = 10'd89;
    localparam logic [TICK_W-1:0]   ONE_HIGH_RST      = 10'd57;
    localparam logic [TICK_W-1:0]   ZERO_HIGH_RST     = 10'd28;
    localparam logic [PERIOD_W-1:0] RESET_PERIODS_RST = 8'd80;

    localparam logic [BIT_W-1:0] BITS_PER_PIXEL = 5'd24;

    // item mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_PUSH = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  blue;
        logic                last_pixel;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic pixel_accepted;
        logic busy_res;
        logic underrun;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        logic               push;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [TICK_W-1:0]   period_last;
        logic [TICK_W-1:0]   one_high;
        logic [TICK_W-1:0]   zero_high;
        logic [PERIOD_W-1:0] reset_periods;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/ws2812_pixel_serializer.sv =====
// Serializer for one LED-chain data line. Each input transaction is either a timer tick
// (mode 0) or a pixel push (mode 1) and yields exactly one result transaction. The block
// takes one transaction per clock while o_in_stall is low. A result passes through the input
// register, the two-entry command queue and the result register before it is presented.
// The single frame sequencer in the back end updates once per transaction and sets that
// one-per-cycle figure.
// Configuration is written through i_cfg_* and is always ready; write only while idle.
// depends on wps_pkg, wps_front, wps_cmd_queue, wps_back
`timescale 1ns / 1ps
`default_nettype none

module ws2812_pixel_serializer import wps_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out_item                  o_out,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    q_push, q_pop;
    t_cmd    front_cmd, q_cmd;
    t_q_stat q_stat;

    assign o_cfg_ready = 1'b1;

    wps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    wps_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    wps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (q_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTH
    // the line is only driven high inside a frame
    a_level_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.line_level) |-> o_out.busy_res)
        else $error("line high outside a frame");

    // a push never advances time, so it cannot raise the line or end a frame
    a_push_no_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.pixel_accepted) |-> (!o_out.line_level && !o_out.underrun))
        else $error("pixel push produced tick effects");

    // queue never popped while empty nor pushed while full
    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty) && !(q_push && q_stat.full))
        else $error("command queue overflow or underflow");
`endif

endmodule

`default_nettype wire

// ===== hdl/wps_front.sv =====
// input stage: takes transactions, classifies them into commands
// depends on wps_pkg; feeds wps_cmd_queue
`timescale 1ns / 1ps
`default_nettype none

module wps_front import wps_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in,
    output logic          o_in_stall,
    input  wire t_q_stat  i_q_stat,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept;

    assign o_in_stall = r_valid && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_stat.full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid     = 1'b1;
            n_cmd.push  = (i_in.mode == MODE_PUSH);
            n_cmd.pixel = {i_in.green, i_in.red, i_in.blue};
            n_cmd.last  = i_in.last_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

// ===== hdl/wps_cmd_queue.sv =====
// two-entry command queue between front and back
// depends on wps_pkg
`timescale 1ns / 1ps
`default_nettype none

module wps_cmd_queue import wps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_q_stat   o_stat
);

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count, n_count;

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wps_back.sv =====
// waveform engine: frame sequencer, pixel buffer, config registers, result register
// depends on wps_pkg; pops commands from wps_cmd_queue
`timescale 1ns / 1ps
`default_nettype none

module wps_back import wps_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    input  wire t_q_stat               i_q_stat,
    output logic                       o_pop,
    output logic                       o_out_valid,
    output t_out_item                  o_out,
    input  wire logic                  i_out_stall
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RESET = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    t_cfg r_cfg;

    logic [1:0]          r_phase, n_phase;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [PIXEL_W-1:0]  r_shift, n_shift;
    logic                r_cur_last, n_cur_last;
    logic [PIXEL_W-1:0]  r_buf_pixel, n_buf_pixel;
    logic                r_buf_full, n_buf_full;
    logic                r_buf_last, n_buf_last;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic [TICK_W-1:0] high_ticks;

    assign o_pop       = !i_q_stat.empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_period    = r_period;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_cur_last  = r_cur_last;
        n_buf_pixel = r_buf_pixel;
        n_buf_full  = r_buf_full;
        n_buf_last  = r_buf_last;
        n_out       = '0;
        high_ticks  = '0;

        if (i_cmd.push) begin
            if (!r_buf_full) begin
                n_buf_pixel          = i_cmd.pixel;
                n_buf_last           = i_cmd.last;
                n_buf_full           = 1'b1;
                n_out.pixel_accepted = 1'b1;
            end
            n_out.busy_res = (r_phase != PH_IDLE);
        end else begin
            // frame start, with immediate load when no reset periods
            if (r_phase == PH_IDLE && r_buf_full) begin
                n_phase  = PH_RESET;
                n_tick   = '0;
                n_period = '0;
                if (r_cfg.reset_periods == '0) begin
                    n_shift    = r_buf_pixel;
                    n_cur_last = r_buf_last;
                    n_buf_full = 1'b0;
                    n_bit      = '0;
                    n_phase    = PH_DATA;
                end
            end
            n_out.busy_res = (n_phase != PH_IDLE);

            high_ticks = n_shift[PIXEL_W-1] ? r_cfg.one_high : r_cfg.zero_high;
            if (n_phase == PH_DATA) begin
                n_out.line_level = (n_tick < high_ticks);
            end

            if (n_phase != PH_IDLE) begin
                if (n_tick >= r_cfg.period_last) begin
                    n_tick = '0;
                    if (n_phase == PH_RESET) begin
                        n_period = n_period + 8'd1;
                        if (n_period >= r_cfg.reset_periods) begin
                            if (n_buf_full) begin
                                n_shift    = r_buf_pixel;
                                n_cur_last = r_buf_last;
                                n_buf_full = 1'b0;
                                n_bit      = '0;
                                n_phase    = PH_DATA;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end else begin
                        n_bit   = n_bit + 5'd1;
                        n_shift = {n_shift[PIXEL_W-2:0], 1'b0};
                        if (n_bit >= BITS_PER_PIXEL) begin
                            n_bit = '0;
                            if (n_cur_last) begin
                                n_phase = PH_IDLE;
                            end else if (n_buf_full) begin
                                n_shift    = r_buf_pixel;
                                n_cur_last = r_buf_last;
                                n_buf_full = 1'b0;
                                n_phase    = PH_DATA;
                            end else begin
                                n_out.underrun = 1'b1;
                                n_phase        = PH_IDLE;
                            end
                        end
                    end
                end else begin
                    n_tick = n_tick + 10'd1;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_last   <= PERIOD_LAST_RST;
            r_cfg.one_high      <= ONE_HIGH_RST;
            r_cfg.zero_high     <= ZERO_HIGH_RST;
            r_cfg.reset_periods <= RESET_PERIODS_RST;
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_period    <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_cur_last  <= 1'b0;
            r_buf_full  <= 1'b0;
            r_buf_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PERIOD_LAST:   r_cfg.period_last   <= i_cfg_data;
                    REG_ONE_HIGH:      r_cfg.one_high      <= i_cfg_data;
                    REG_ZERO_HIGH:     r_cfg.zero_high     <= i_cfg_data;
                    REG_RESET_PERIODS: r_cfg.reset_periods <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_phase    <= n_phase;
                r_tick     <= n_tick;
                r_period   <= n_period;
                r_bit      <= n_bit;
                r_shift    <= n_shift;
                r_cur_last <= n_cur_last;
                r_buf_full <= n_buf_full;
                r_buf_last <= n_buf_last;
            end
            r_out_valid <= n_out_valid;
        end
        if (o_pop) begin
            r_buf_pixel <= n_buf_pixel;
            r_out       <= n_out;
        end
    end

endmodule

`default_nettype wire
